### hw/rtl/u8dlc_pkg.sv
// ----------------------------------------------------------------------------
// u8dlc_pkg
// Shared constants and types of the UTF-8 decoder with line and column
// tracking: lead byte patterns, field widths and the result record.
// ----------------------------------------------------------------------------
package u8dlc_pkg;

  // Default widths of the internal counters.
  localparam int unsigned OffsetBitsDefault = 32;
  localparam int unsigned LineBitsDefault   = 16;
  localparam int unsigned ColumnBitsDefault = 16;

  // Fixed widths of the result fields.
  localparam int unsigned CodeBits      = 21;
  localparam int unsigned OffsetOutBits = 32;
  localparam int unsigned LineOutBits   = 16;
  localparam int unsigned ColumnOutBits = 16;

  // Each continuation byte adds six payload bits.
  localparam int unsigned ContBits = 6;
  // Widest open character: three lead bits plus two continuation groups.
  localparam int unsigned PartialBits = CodeBits - ContBits;

  // Lead byte classification.
  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] Lead2Mask  = 8'hE0;
  localparam logic [7:0] Lead2Pat   = 8'hC0;
  localparam logic [7:0] Lead3Mask  = 8'hF0;
  localparam logic [7:0] Lead3Pat   = 8'hE0;
  localparam logic [7:0] Lead4Mask  = 8'hF8;
  localparam logic [7:0] Lead4Pat   = 8'hF0;
  localparam logic [7:0] Lead2Data  = 8'h1F;
  localparam logic [7:0] Lead3Data  = 8'h0F;
  localparam logic [7:0] Lead4Data  = 8'h07;
  localparam logic [7:0] ContData   = 8'h3F;

  // Code point of a newline.
  localparam logic [CodeBits-1:0] NewlineCode = CodeBits'(8'h0A);

  // One decoded character.
  typedef struct packed {
    logic [CodeBits-1:0]      char_code;
    logic [OffsetOutBits-1:0] start_offset;
    logic [LineOutBits-1:0]   line_number;
    logic [ColumnOutBits-1:0] column_number;
    logic                     bad_lead;
    logic                     cut_short;
  } u8dlc_result_t;

endpackage

### hw/rtl/u8dlc_core.sv
// ----------------------------------------------------------------------------
// u8dlc_core
// Decoder state and the per-byte step: lead classification, continuation
// merge, cut-short fill, byte offset and line/column counters.
// ----------------------------------------------------------------------------
module u8dlc_core
  import u8dlc_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OffsetBitsDefault,
  parameter int unsigned LINE_BITS   = LineBitsDefault,
  parameter int unsigned COLUMN_BITS = ColumnBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    data_byte_i,
  input  logic          end_of_input_i,
  output logic          emit_o,
  output u8dlc_result_t result_o
);

  logic [PartialBits-1:0] partial_q, partial_d;
  logic [1:0]             bytes_left_q, bytes_left_d;
  logic [OFFSET_BITS-1:0] lead_offset_q, lead_offset_d;
  logic [OFFSET_BITS-1:0] byte_count_q, byte_count_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COLUMN_BITS-1:0] column_q, column_d;

  logic [CodeBits-1:0]    code;
  logic [CodeBits-1:0]    code_fin;
  logic [1:0]             need;
  logic                   bad;
  logic                   hold;
  logic                   newline;
  logic [OFFSET_BITS-1:0] offset;
  logic [LINE_BITS-1:0]   line_new;
  logic [COLUMN_BITS-1:0] column_new;

  logic [OFFSET_BITS+OffsetOutBits-1:0] offset_ext;
  logic [LINE_BITS+LineOutBits-1:0]     line_ext;
  logic [COLUMN_BITS+ColumnOutBits-1:0] column_ext;

  // Decode the byte against the open character, if any.
  always_comb begin
    code   = '0;
    need   = 2'd0;
    bad    = 1'b0;
    offset = byte_count_q;
    if (bytes_left_q == 2'd0) begin
      if (data_byte_i < AsciiLimit) begin
        code = CodeBits'(data_byte_i);
      end else if ((data_byte_i & Lead2Mask) == Lead2Pat) begin
        code = CodeBits'(data_byte_i & Lead2Data);
        need = 2'd1;
      end else if ((data_byte_i & Lead3Mask) == Lead3Pat) begin
        code = CodeBits'(data_byte_i & Lead3Data);
        need = 2'd2;
      end else if ((data_byte_i & Lead4Mask) == Lead4Pat) begin
        code = CodeBits'(data_byte_i & Lead4Data);
        need = 2'd3;
      end else begin
        bad = 1'b1;
      end
    end else begin
      offset = lead_offset_q;
      code   = {partial_q, data_byte_i[ContBits-1:0]};
      need   = bytes_left_q - 2'd1;
    end
  end

  // Fill missing continuation groups with zeros when the text ends early.
  always_comb begin
    case (need)
      2'd1:    code_fin = {code[CodeBits-ContBits-1:0], {ContBits{1'b0}}};
      2'd2:    code_fin = {code[CodeBits-2*ContBits-1:0], {(2*ContBits){1'b0}}};
      2'd3:    code_fin = {code[CodeBits-3*ContBits-1:0], {(3*ContBits){1'b0}}};
      default: code_fin = code;
    endcase
  end

  assign hold    = (need != 2'd0) && !end_of_input_i;
  assign emit_o  = !hold;
  assign newline = (code_fin == NewlineCode);

  // Line and column after this character, both saturating.
  always_comb begin
    line_new   = line_q;
    column_new = column_q;
    if (newline) begin
      column_new = '0;
      if (line_q != '1) begin
        line_new = line_q + LINE_BITS'(1);
      end
    end else if (column_q != '1) begin
      column_new = column_q + COLUMN_BITS'(1);
    end
  end

  // Next state.
  always_comb begin
    partial_d     = partial_q;
    bytes_left_d  = bytes_left_q;
    lead_offset_d = lead_offset_q;
    byte_count_d  = byte_count_q;
    line_d        = line_q;
    column_d      = column_q;
    if (step_i) begin
      byte_count_d = byte_count_q + OFFSET_BITS'(1);
      if (hold) begin
        partial_d     = code[PartialBits-1:0];
        bytes_left_d  = need;
        lead_offset_d = offset;
      end else begin
        partial_d    = '0;
        bytes_left_d = 2'd0;
        line_d       = line_new;
        column_d     = column_new;
      end
      // The last byte of a text puts everything back to the start.
      if (end_of_input_i) begin
        partial_d     = '0;
        bytes_left_d  = 2'd0;
        lead_offset_d = '0;
        byte_count_d  = '0;
        line_d        = LINE_BITS'(1);
        column_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q     <= '0;
      bytes_left_q  <= 2'd0;
      lead_offset_q <= '0;
      byte_count_q  <= '0;
      line_q        <= LINE_BITS'(1);
      column_q      <= '0;
    end else begin
      partial_q     <= partial_d;
      bytes_left_q  <= bytes_left_d;
      lead_offset_q <= lead_offset_d;
      byte_count_q  <= byte_count_d;
      line_q        <= line_d;
      column_q      <= column_d;
    end
  end

  // Result fields, fitted to their fixed widths.
  assign offset_ext = {{OffsetOutBits{1'b0}}, offset};
  assign line_ext   = {{LineOutBits{1'b0}}, line_new};
  assign column_ext = {{ColumnOutBits{1'b0}}, column_new};

  assign result_o.char_code     = code_fin;
  assign result_o.start_offset  = offset_ext[OffsetOutBits-1:0];
  assign result_o.line_number   = line_ext[LineOutBits-1:0];
  assign result_o.column_number = column_ext[ColumnOutBits-1:0];
  assign result_o.bad_lead      = bad;
  assign result_o.cut_short     = (need != 2'd0);

  // A text end leaves the decoder at the start of a fresh text.
  a_eoi_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && end_of_input_i |=>
      byte_count_q == '0 && bytes_left_q == 2'd0 && line_q == LINE_BITS'(1))
    else $error("decoder state not restarted after end of input");

  // A step that finishes no character leaves a character open.
  a_hold_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !emit_o |=> bytes_left_q != 2'd0)
    else $error("held character without pending continuation bytes");

  // A newline clears the column.
  a_newline_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && emit_o && newline && !end_of_input_i |=> column_q == '0)
    else $error("column not cleared after newline");

  // Lines are counted from one and never wrap to zero.
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0)
    else $error("line counter reached zero");

endmodule

### hw/rtl/utf8_decoder_line_column.sv
// ----------------------------------------------------------------------------
// utf8_decoder_line_column
// Lenient UTF-8 decoder that tags each character with its byte offset,
// line and column.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one byte per transaction
//   with an end_of_input_i flag on the last byte of a text. Output channel
//   (out_valid_o / out_stall_i) carries one decoded character per
//   transaction. A transaction completes at a clock edge where valid is high
//   and stall is low.
//   The block takes one byte per cycle while in_stall_o is low. A byte is
//   held in an input register, passes the decode step, and the character it
//   finishes is loaded into the result register, from which it is presented
//   on the output until it is taken.
//   Continuation bytes that do not finish a character produce no output.
//   A byte with end_of_input_i set finishes any open character (zero-filled,
//   cut_short set) and restarts offset, line and column for the next text.
//   Reset clears both valid flags and starts at offset 0, line 1, column 0.
//   While the receiver stalls, the result register holds; the input register
//   still absorbs one more byte and keeps moving bytes that finish nothing.
// ----------------------------------------------------------------------------
module utf8_decoder_line_column
  import u8dlc_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OffsetBitsDefault,
  parameter int unsigned LINE_BITS   = LineBitsDefault,
  parameter int unsigned COLUMN_BITS = ColumnBitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               data_byte_i,
  input  logic                     end_of_input_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [CodeBits-1:0]      char_code_o,
  output logic [OffsetOutBits-1:0] start_offset_o,
  output logic [LineOutBits-1:0]   line_number_o,
  output logic [ColumnOutBits-1:0] column_number_o,
  output logic                     bad_lead_o,
  output logic                     cut_short_o
);

  logic          in_valid_q, in_valid_d;
  logic [7:0]    byte_q;
  logic          eoi_q;
  logic          out_valid_q, out_valid_d;
  u8dlc_result_t result_q;
  u8dlc_result_t step_result;
  logic          step_emit;
  logic          step;
  logic          out_free;
  logic          in_take;

  // Handshake: the held byte moves on unless its result finds no room.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && (!step_emit || out_free);
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = step && step_emit;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input byte register.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= data_byte_i;
      eoi_q  <= end_of_input_i;
    end
  end

  // Decode step and its state.
  u8dlc_core #(
    .OFFSET_BITS(OFFSET_BITS),
    .LINE_BITS  (LINE_BITS),
    .COLUMN_BITS(COLUMN_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .data_byte_i   (byte_q),
    .end_of_input_i(eoi_q),
    .emit_o        (step_emit),
    .result_o      (step_result)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (step && step_emit) begin
      result_q <= step_result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign char_code_o     = result_q.char_code;
  assign start_offset_o  = result_q.start_offset;
  assign line_number_o   = result_q.line_number;
  assign column_number_o = result_q.column_number;
  assign bad_lead_o      = result_q.bad_lead;
  assign cut_short_o     = result_q.cut_short;

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UTF-8 decoder with line and column tracking.
// Bytes are fed through the valid/stall input channel with random gaps, and
// a character tracker predicts every decoded character. Each character taken
// from the output channel under random stalls is checked against the oldest
// prediction. The stimulus covers lead and continuation extremes, invalid
// leads, malformed continuations, texts that end mid-character, and a burst
// with no idling on either side.
// ----------------------------------------------------------------------------
module testbench
  import u8dlc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Predicts decoded characters from accepted bytes and checks the results.
  class char_tracker;
    logic [CodeBits-1:0]      open_bits;
    logic [1:0]               groups_left;
    logic [OffsetOutBits-1:0] open_offset;
    logic [OffsetOutBits-1:0] next_offset;
    logic [LineOutBits-1:0]   line_no;
    logic [ColumnOutBits-1:0] col_no;
    u8dlc_result_t            expected_chars[$];
    int unsigned              errors;

    function new();
      errors = 0;
      restart();
    endfunction

    // State of a fresh text: offset 0, line 1, column 0.
    function void restart();
      open_bits   = '0;
      groups_left = '0;
      open_offset = '0;
      next_offset = '0;
      line_no     = LineOutBits'(1);
      col_no      = '0;
    endfunction

    // Notes one accepted byte and queues the character it finishes, if any.
    function void take_byte(logic [7:0] b, logic last);
      logic [CodeBits-1:0]      code;
      logic [OffsetOutBits-1:0] pos;
      int unsigned              need;
      logic                     bad;
      u8dlc_result_t            r;
      bad = 1'b0;
      if (groups_left == 0) begin
        pos = next_offset;
        need = 0;
        code = '0;
        if (b < AsciiLimit) begin
          code = CodeBits'(b);
        end else if ((b & Lead2Mask) == Lead2Pat) begin
          code = CodeBits'(b & Lead2Data);
          need = 1;
        end else if ((b & Lead3Mask) == Lead3Pat) begin
          code = CodeBits'(b & Lead3Data);
          need = 2;
        end else if ((b & Lead4Mask) == Lead4Pat) begin
          code = CodeBits'(b & Lead4Data);
          need = 3;
        end else begin
          bad = 1'b1;
        end
      end else begin
        // Continuation bytes are taken unchecked; only the low six bits count.
        pos = open_offset;
        code = (open_bits << ContBits) | CodeBits'(b & ContData);
        need = groups_left - 1;
      end
      next_offset = next_offset + 1'b1;

      if (need != 0 && !last) begin
        open_bits   = code;
        groups_left = 2'(need);
        open_offset = pos;
        return;
      end
      // A text that ends mid-character gets its missing groups as zeros.
      r.cut_short = (need != 0);
      code = code << (ContBits * need);
      open_bits   = '0;
      groups_left = '0;

      // Newline moves to the next line; line and column saturate.
      if (code == NewlineCode) begin
        if (line_no != '1) line_no = line_no + 1'b1;
        col_no = '0;
      end else if (col_no != '1) begin
        col_no = col_no + 1'b1;
      end

      r.char_code     = code;
      r.start_offset  = pos;
      r.line_number   = line_no;
      r.column_number = col_no;
      r.bad_lead      = bad;
      expected_chars.push_back(r);
      if (last) restart();
    endfunction

    function void compare(string field, longint unsigned want, longint unsigned seen);
      if (want != seen) begin
        errors++;
        $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, seen);
      end
    endfunction

    // Checks one character taken from the output against the oldest prediction.
    function void check_char(u8dlc_result_t got);
      u8dlc_result_t want;
      if (expected_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected character, expected none actual code 0x%0h",
                 $time, got.char_code);
        return;
      end
      want = expected_chars.pop_front();
      compare("char_code", want.char_code, got.char_code);
      compare("start_offset", want.start_offset, got.start_offset);
      compare("line_number", want.line_number, got.line_number);
      compare("column_number", want.column_number, got.column_number);
      compare("bad_lead", want.bad_lead, got.bad_lead);
      compare("cut_short", want.cut_short, got.cut_short);
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [7:0]               data_byte_i = '0;
  logic                     end_of_input_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [CodeBits-1:0]      char_code_o;
  logic [OffsetOutBits-1:0] start_offset_o;
  logic [LineOutBits-1:0]   line_number_o;
  logic [ColumnOutBits-1:0] column_number_o;
  logic                     bad_lead_o;
  logic                     cut_short_o;

  char_tracker tracker = new();
  // When set, neither side idles.
  bit          quiet = 1'b0;
  int          stall_left = 0;
  logic [7:0]  text_bytes[$];

  utf8_decoder_line_column dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .char_code_o    (char_code_o),
    .start_offset_o (start_offset_o),
    .line_number_o  (line_number_o),
    .column_number_o(column_number_o),
    .bad_lead_o     (bad_lead_o),
    .cut_short_o    (cut_short_o)
  );

  always #5 clk_i = ~clk_i;

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Output side: take characters and stall at random.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_char({char_code_o, start_offset_o, line_number_o,
                          column_number_o, bad_lead_o, cut_short_o});
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = pick_gap();
    end
  end

  // Sends one byte transaction; valid stays high unless a gap follows.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    end_of_input_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_byte(b, last);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Sends the built text, marking its final byte as the end if asked.
  task automatic send_text(input bit ends);
    for (int i = 0; i < text_bytes.size(); i++) begin
      send_byte(text_bytes[i], ends && (i == text_bytes.size() - 1));
    end
  endtask

  // Holds the input back until every predicted character has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.expected_chars.size() != 0);
  endtask

  // Appends one random character, mostly well formed.
  task automatic add_char();
    int  kind;
    int  conts;
    bit  broken;
    kind = $urandom_range(0, 99);
    conts = 0;
    broken = 1'b0;
    if (kind < 40) begin
      text_bytes.push_back(8'($urandom_range(0, 127)));
    end else if (kind < 50) begin
      text_bytes.push_back(8'h0A);
    end else if (kind < 92) begin
      conts = $urandom_range(1, 3);
      broken = (kind >= 86);
    end else if ($urandom_range(0, 1) == 0) begin
      text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
    end else begin
      text_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
    end
    if (conts == 1) text_bytes.push_back(Lead2Pat | 8'($urandom_range(0, 31)));
    if (conts == 2) text_bytes.push_back(Lead3Pat | 8'($urandom_range(0, 15)));
    if (conts == 3) text_bytes.push_back(Lead4Pat | 8'($urandom_range(0, 7)));
    repeat (conts) begin
      if (broken) text_bytes.push_back(8'($urandom_range(0, 255)));
      else text_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
    end
  endtask

  // Builds a random text; an ending text may be cut inside its last character.
  task automatic build_text(input bit ends);
    int n;
    int last_start;
    int len;
    text_bytes.delete();
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
    last_start = 0;
    repeat (n) begin
      last_start = text_bytes.size();
      add_char();
    end
    len = text_bytes.size() - last_start;
    if (ends && len > 1 && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, len - 1)) void'(text_bytes.pop_back());
    end
  endtask

  initial begin
    int random_bytes;
    bit ends;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: ASCII extremes, newline, smallest and largest multi-byte
    // codes, invalid leads, an overlong newline and a malformed continuation.
    text_bytes = '{8'h00, 8'h7F, 8'h0A, 8'hC0, 8'h80, 8'hE0, 8'h80, 8'h80,
                   8'hEF, 8'hBF, 8'hBF, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h80,
                   8'hFF, 8'hC0, 8'h8A, 8'hE1, 8'h00, 8'hFF};
    send_text(1'b0);
    // Text ending inside a character, then a lead that is the last byte.
    text_bytes = '{8'hF0, 8'hBF};
    send_text(1'b1);
    text_bytes = '{8'hE2};
    send_text(1'b1);
    drain();

    // Burst without idling over several lines, with a two-byte character before the final byte.
    quiet = 1'b1;
    repeat (40) send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
    repeat (20) send_byte(8'h0A, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'h41, 1'b1);
    quiet = 1'b0;
    drain();

    // Random texts, some without idling, some followed by a full drain.
    random_bytes = 0;
    while (random_bytes < 1600) begin
      ends = ($urandom_range(0, 99) < 85);
      quiet = ($urandom_range(0, 9) == 0);
      build_text(ends);
      random_bytes += text_bytes.size();
      send_text(ends);
      if ($urandom_range(0, 9) == 0) drain();
    end
    quiet = 1'b0;

    drain();
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("utf8_decoder_line_column: match");
    end else begin
      $display("utf8_decoder_line_column: mismatch");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #10_000_000;
    $display("utf8_decoder_line_column: mismatch");
    $finish;
  end

endmodule
